// ===== rtl/tli_pkg.sv =====
// Shared types and constants for the table linear interpolation core.
// No dependencies; used by tli_div and table_linear_interpolation_core.
package tli_pkg;

  localparam int unsigned DefMaxPoints  = 64;
  localparam int unsigned DefMaxColumns = 8;

  localparam int unsigned NumW  = 49;  // |x - t0| * 2^16
  localparam int unsigned DenW  = 33;  // |t1 - t0|
  localparam int unsigned FracW = 17;  // fraction in [0, 1.0] as Q.16
  localparam logic [FracW-1:0] FracOne = 17'h10000;

  typedef enum logic [1:0] {
    OP_TIME   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_POINTS  = 2'd0,
    REG_COLUMNS = 2'd1,
    REG_RSVD2   = 2'd2,
    REG_RSVD3   = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DIV_WAIT,
    ST_COL_RD0,
    ST_COL_RD1,
    ST_COL_DIFF,
    ST_COL_OUT
  } state_e;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

endpackage

// ===== rtl/table_linear_interpolation_core.sv =====
// Table linear interpolation core: top level with table memories and sequencer.
// Depends on tli_pkg and tli_div.
// A load is written to its table when it is accepted. A query scans the time table entry
// by entry (read, then compare), waits on the serial divider when it interpolates, then
// reads the lower and upper sample of each column on the single sample memory read port
// and waits on output back-pressure; the input is not ready until the query is done.
// Reset: registers return to 1 point and 8 columns; table contents are undefined.
module table_linear_interpolation_core #(
  parameter int unsigned MAX_POINTS  = tli_pkg::DefMaxPoints,
  parameter int unsigned MAX_COLUMNS = tli_pkg::DefMaxColumns
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [5:0] entry_index, [8:6] column_index, [40:9] time_value, [72:41] sample_value
  input  logic [79:0] s_axis_tdata,
  // [1:0] op
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] result_value, [34:32] result_column
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned PW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned NW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned CW   = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned SD   = MAX_POINTS * MAX_COLUMNS;
  localparam int unsigned SAW  = (SD > 1) ? $clog2(SD) : 1;
  localparam int unsigned ProdW = 33 + tli_pkg::FracW + 1;

  // Unpack the input transaction.
  logic [1:0]         in_op;
  logic [5:0]         in_row;
  logic [2:0]         in_col;
  logic signed [31:0] in_time, in_sample;
  assign in_op     = s_axis_tuser;
  assign in_row    = s_axis_tdata[5:0];
  assign in_col    = s_axis_tdata[8:6];
  assign in_time   = s_axis_tdata[40:9];
  assign in_sample = s_axis_tdata[72:41];

  tli_pkg::state_e state_q, state_d;

  logic [6:0] points_q;
  logic [3:0] columns_q;
  logic [NW-1:0] n_q, n_d, cnt_q, cnt_d, sel_q, sel_d;
  logic [CW-1:0] cols_q, cols_d, c_q, c_d;
  logic               interp_q, interp_d;
  logic signed [31:0] x_q, x_d, prev_q, prev_d, y0_q, y0_d;
  logic signed [32:0] diff_q, diff_d;
  logic [tli_pkg::FracW-1:0] frac_q, frac_d;

  logic        out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [31:0] out_value_q, out_value_d;
  logic [2:0]  out_col_q, out_col_d;

  logic in_fire, out_free;
  assign s_axis_tready = (state_q == tli_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Configuration: always ready; write only while idle, which the block itself does not enforce.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q  <= 7'd1;
      columns_q <= 4'd8;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tli_pkg::REG_POINTS:  points_q  <= cfg_data_i[6:0];
        tli_pkg::REG_COLUMNS: columns_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Time store: one write port, one registered read port.
  logic [31:0]   time_mem [MAX_POINTS];
  logic [PW-1:0] t_raddr;
  logic signed [31:0] t_rdata_q;
  logic t_we;
  assign t_we = in_fire && (in_op == tli_pkg::OP_TIME) && (32'(in_row) < MAX_POINTS);
  always_ff @(posedge clk_i) begin
    if (t_we) begin
      time_mem[PW'(in_row)] <= in_time;
    end
    t_rdata_q <= time_mem[t_raddr];
  end

  // Sample store, indexed row * MAX_COLUMNS + column.
  logic [31:0]    samp_mem [SD];
  logic [SAW-1:0] s_raddr, s_waddr;
  logic signed [31:0] s_rdata_q;
  logic s_we;
  assign s_we = in_fire && (in_op == tli_pkg::OP_SAMPLE) && (32'(in_row) < MAX_POINTS)
                && (32'(in_col) < MAX_COLUMNS);
  assign s_waddr = SAW'(32'(in_row) * MAX_COLUMNS + 32'(in_col));
  always_ff @(posedge clk_i) begin
    if (s_we) begin
      samp_mem[s_waddr] <= in_sample;
    end
    s_rdata_q <= samp_mem[s_raddr];
  end

  // Fraction divider.
  tli_pkg::div_req_t        div_req;
  logic                     div_done;
  logic [tli_pkg::NumW-1:0] div_quo;

  tli_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Scan compare and fraction setup.
  logic               found, at_end;
  logic signed [32:0] num_s, den_s;
  logic [32:0]        num_mag, den_mag;
  logic               div_ok;
  assign found   = t_rdata_q >= x_q;
  assign at_end  = (cnt_q + 1'b1) == n_q;
  assign num_s   = 33'(x_q) - 33'(prev_q);
  assign den_s   = 33'(t_rdata_q) - 33'(prev_q);
  assign num_mag = num_s[32] ? 33'(-num_s) : 33'(num_s);
  assign den_mag = den_s[32] ? 33'(-den_s) : 33'(den_s);
  // A quotient of opposite signs or zero clamps to zero: skip the divider.
  assign div_ok  = (num_s != 0) && (num_s[32] == den_s[32]);

  logic [ProdW-1:0] prod;
  logic signed [ProdW-1:0] prod_s;
  assign prod_s = ProdW'(diff_q) * $signed({1'b0, frac_q});
  assign prod   = prod_s;

  logic [NW-1:0] row0;
  assign row0 = interp_q ? sel_q - 1'b1 : sel_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tli_pkg::ST_IDLE:
        if (in_fire && in_op == tli_pkg::OP_QUERY) state_d = tli_pkg::ST_SCAN_RD;
      tli_pkg::ST_SCAN_RD: state_d = tli_pkg::ST_SCAN_CMP;
      tli_pkg::ST_SCAN_CMP: begin
        if (found) begin
          if (cnt_q != 0 && t_rdata_q != prev_q && div_ok) state_d = tli_pkg::ST_DIV_WAIT;
          else state_d = tli_pkg::ST_COL_RD0;
        end else if (at_end) begin
          state_d = tli_pkg::ST_COL_RD0;
        end else begin
          state_d = tli_pkg::ST_SCAN_RD;
        end
      end
      tli_pkg::ST_DIV_WAIT: if (div_done) state_d = tli_pkg::ST_COL_RD0;
      tli_pkg::ST_COL_RD0:  state_d = tli_pkg::ST_COL_RD1;
      tli_pkg::ST_COL_RD1:  state_d = tli_pkg::ST_COL_DIFF;
      tli_pkg::ST_COL_DIFF: state_d = tli_pkg::ST_COL_OUT;
      tli_pkg::ST_COL_OUT: begin
        if (out_free) begin
          state_d = (c_q + 1'b1 == cols_q) ? tli_pkg::ST_IDLE : tli_pkg::ST_COL_RD0;
        end
      end
      default: state_d = tli_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    n_d         = n_q;
    cols_d      = cols_q;
    cnt_d       = cnt_q;
    sel_d       = sel_q;
    c_d         = c_q;
    interp_d    = interp_q;
    x_d         = x_q;
    prev_d      = prev_q;
    y0_d        = y0_q;
    diff_d      = diff_q;
    frac_d      = frac_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_last_d  = out_last_q;
    out_value_d = out_value_q;
    out_col_d   = out_col_q;
    t_raddr     = PW'(cnt_q);
    s_raddr     = SAW'(32'(row0) * MAX_COLUMNS + 32'(c_q));
    div_req.start = 1'b0;
    div_req.num   = {num_mag, 16'h0000};
    div_req.den   = den_mag;
    unique case (state_q)
      tli_pkg::ST_IDLE: begin
        // Clamp the register counts while idle; the values taken when a query is accepted hold for it.
        if (points_q == 0) n_d = NW'(1);
        else if (32'(points_q) > MAX_POINTS) n_d = NW'(MAX_POINTS);
        else n_d = NW'(points_q);
        if (columns_q == 0) cols_d = CW'(1);
        else if (32'(columns_q) > MAX_COLUMNS) cols_d = CW'(MAX_COLUMNS);
        else cols_d = CW'(columns_q);
        cnt_d    = '0;
        c_d      = '0;
        interp_d = 1'b0;
        frac_d   = '0;
        x_d      = in_time;
      end
      tli_pkg::ST_SCAN_RD: ;
      tli_pkg::ST_SCAN_CMP: begin
        if (found) begin
          sel_d = cnt_q;
          if (cnt_q != 0 && t_rdata_q != prev_q) begin
            interp_d      = 1'b1;
            div_req.start = div_ok;
          end
        end else if (at_end) begin
          sel_d = cnt_q;
        end else begin
          prev_d = t_rdata_q;
          cnt_d  = cnt_q + 1'b1;
        end
      end
      tli_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          frac_d = (div_quo > tli_pkg::NumW'(tli_pkg::FracOne)) ? tli_pkg::FracOne
                                                                : div_quo[tli_pkg::FracW-1:0];
        end
      end
      tli_pkg::ST_COL_RD0: ;
      tli_pkg::ST_COL_RD1: begin
        s_raddr = SAW'(32'(sel_q) * MAX_COLUMNS + 32'(c_q));
        y0_d    = s_rdata_q;
      end
      tli_pkg::ST_COL_DIFF: diff_d = 33'(s_rdata_q) - 33'(y0_q);
      tli_pkg::ST_COL_OUT: begin
        if (out_free) begin
          // Arithmetic shift floors the product.
          out_value_d = 32'(y0_q) + prod[47:16];
          out_col_d   = 3'(c_q);
          out_last_d  = (c_q + 1'b1 == cols_q);
          out_valid_d = 1'b1;
          c_d         = c_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tli_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      c_q         <= '0;
      n_q         <= NW'(1);
      cols_q      <= CW'(1);
      interp_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      c_q         <= c_d;
      n_q         <= n_d;
      cols_q      <= cols_d;
      interp_q    <= interp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q       <= sel_d;
    x_q         <= x_d;
    prev_q      <= prev_d;
    y0_q        <= y0_d;
    diff_q      <= diff_d;
    frac_q      <= frac_d;
    out_last_q  <= out_last_d;
    out_value_q <= out_value_d;
    out_col_q   <= out_col_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {5'b0, out_col_q, out_value_q};

  // Scan never reads past the valid points.
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tli_pkg::ST_SCAN_CMP) |-> (cnt_q < n_q))
    else $error("scan index beyond point count");

  // Fraction stays within [0, 1.0] while columns are produced.
  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tli_pkg::ST_COL_OUT) |-> (frac_q <= tli_pkg::FracOne))
    else $error("fraction out of range");

  // Interpolation always has a predecessor row.
  a_interp_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tli_pkg::ST_COL_RD0 && interp_q) |-> (sel_q != 0))
    else $error("interpolation without lower row");

  // The column sequence does not advance while the output is stalled.
  a_busy_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tli_pkg::ST_COL_OUT && !out_free) |=> (state_q == tli_pkg::ST_COL_OUT))
    else $error("column advanced while output stalled");

endmodule

// ===== rtl/tli_div.sv =====
// Bit-serial restoring divider for the interpolation fraction.
// Depends on tli_pkg for widths and the request struct.
module tli_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tli_pkg::div_req_t       req_i,
  output logic                    done_o,
  output logic [tli_pkg::NumW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(tli_pkg::NumW + 1);
  localparam int unsigned RemW = tli_pkg::DenW + 1;

  logic [RemW-1:0]          rem_q, rem_d, rem_sh;
  logic [tli_pkg::NumW-1:0] quo_q, quo_d;
  logic [tli_pkg::DenW-1:0] den_q, den_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     busy_q, busy_d, done_q, done_d;
  logic                     ge;

  always_comb begin
    rem_sh = {rem_q[RemW-2:0], quo_q[tli_pkg::NumW-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? rem_sh - {1'b0, den_q} : rem_sh;
      quo_d = {quo_q[tli_pkg::NumW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(tli_pkg::NumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for table_linear_interpolation_core: loads, queries and
// random stalls on both streams, checked against a behavioral interpolation predictor.
// Depends on tli_pkg and the core RTL only.
module tb;

  typedef struct {
    tli_pkg::op_e op;
    logic [5:0]   row;
    logic [2:0]   col;
    logic [31:0]  tval;
    logic [31:0]  sval;
  } table_item_t;

  typedef struct {
    logic [31:0] value;
    logic [2:0]  column;
    logic        last;
  } column_result_t;

  localparam int WatchdogLimit = 5000;
  localparam int NumPhases     = 8;
  localparam int ItemsPerPhase = 12;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [5:0] entry_index, [8:6] column_index, [40:9] time_value, [72:41] sample_value
  logic [79:0] s_axis_tdata  = '0;
  // [1:0] op
  logic [1:0]  s_axis_tuser  = tli_pkg::OP_NONE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [31:0] result_value, [34:32] result_column
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = tli_pkg::REG_POINTS;
  logic [7:0]  cfg_data_i    = '0;

  // Register settings per phase, including out-of-range counts.
  logic [7:0] points_w  [NumPhases] = '{8'd4, 8'd0, 8'd64, 8'hFF, 8'd10, 8'd2, 8'd16, 8'd33};
  logic [7:0] columns_w [NumPhases] = '{8'd2, 8'd15, 8'd1, 8'd1, 8'hFF, 8'd3, 8'd4, 8'd2};

  table_linear_interpolation_core uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Predictor copy of the block state.
  logic [31:0] time_tbl [64];
  logic [31:0] sample_tbl [64][8];
  logic [6:0]  points_cfg  = 7'd1;
  logic [3:0]  columns_cfg = 4'd8;

  // Generator view: what has been written, to keep queries on written entries.
  logic [31:0] gen_time [64];
  bit          time_known [64];
  bit          sample_known [64][8];
  longint      phase_step;

  table_item_t    pending_q [$];
  column_result_t expected_q [$];
  table_item_t    drv_item;

  bit in_fire, out_fire;
  bit gap_burst, stall_burst;
  bit hold_req, hold_done;
  int gap_left, stall_left, hold_left, idle_cycles;
  int error_count, query_count, result_count;

  // Work out every column result of a query; loads update the table copy.
  function automatic void interpolate_item(table_item_t it);
    int             n, cols, idx, sel;
    longint         x, t0, t1, frac, y0, y1, v;
    bit             interp, found;
    column_result_t r;
    case (it.op)
      tli_pkg::OP_TIME:   time_tbl[it.row] = it.tval;
      tli_pkg::OP_SAMPLE: sample_tbl[it.row][it.col] = it.sval;
      tli_pkg::OP_QUERY: begin
        n    = (points_cfg == 0) ? 1 : ((points_cfg > 64) ? 64 : points_cfg);
        cols = (columns_cfg == 0) ? 1 : ((columns_cfg > 8) ? 8 : columns_cfg);
        x    = longint'($signed(it.tval));
        idx  = n;
        found = 0;
        for (int c = 0; c < n; c++) begin
          if (!found && longint'($signed(time_tbl[c])) >= x) begin
            idx   = c;
            found = 1;
          end
        end
        interp = 0;
        frac   = 0;
        if (idx == n) begin
          sel = n - 1;
        end else if (idx == 0) begin
          sel = 0;
        end else begin
          sel = idx;
          t0  = longint'($signed(time_tbl[idx-1]));
          t1  = longint'($signed(time_tbl[idx]));
          if (t1 != t0) begin
            interp = 1;
            frac   = ((x - t0) * 65536) / (t1 - t0);
            if (frac < 0) frac = 0;
            if (frac > 65536) frac = 65536;
          end
        end
        for (int c = 0; c < cols; c++) begin
          if (interp) begin
            y0 = longint'($signed(sample_tbl[sel-1][c]));
            y1 = longint'($signed(sample_tbl[sel][c]));
            v  = y0 + (((y1 - y0) * frac) >>> 16);  // floor, low product bits dropped
          end else begin
            v = longint'($signed(sample_tbl[sel][c]));
          end
          r.value  = v[31:0];
          r.column = c[2:0];
          r.last   = (c == cols - 1);
          expected_q.push_back(r);
        end
        query_count++;
      end
      default: ;
    endcase
  endfunction

  // Sample both streams at the rising edge; predict on input, check on output.
  always @(posedge clk_i) begin
    column_result_t exp_r;
    in_fire  = s_axis_tvalid && s_axis_tready;
    out_fire = m_axis_tvalid && m_axis_tready;
    if (in_fire) interpolate_item(drv_item);
    if (out_fire) begin
      result_count++;
      if (expected_q.size() == 0) begin
        $error("unexpected result: value %h column %0d last %0b",
               m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast);
        error_count++;
      end else begin
        exp_r = expected_q.pop_front();
        if (m_axis_tdata[31:0] !== exp_r.value) begin
          $error("result_value: expected %h actual %h", exp_r.value, m_axis_tdata[31:0]);
          error_count++;
        end
        if (m_axis_tdata[34:32] !== exp_r.column) begin
          $error("result_column: expected %0d actual %0d", exp_r.column, m_axis_tdata[34:32]);
          error_count++;
        end
        if (m_axis_tlast !== exp_r.last) begin
          $error("last_result: expected %0b actual %0b", exp_r.last, m_axis_tlast);
          error_count++;
        end
      end
    end
    // Watchdog: count stuck cycles only while work is outstanding.
    if (in_fire || out_fire || (cfg_valid_i && cfg_ready_o) ||
        !(pending_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0 || cfg_valid_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Watchdog expired with %0d results outstanding", expected_q.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Input driver: advance on a transaction, hold a random gap before the next item.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        drv_item      = pending_q.pop_front();
        s_axis_tdata  <= {7'd0, drv_item.sval, drv_item.tval, drv_item.col, drv_item.row};
        s_axis_tuser  <= drv_item.op;
        s_axis_tvalid <= 1'b1;
        gap_left = gap_burst ? 0 : $urandom_range(0, 14);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall per result, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (out_fire) stall_left = stall_burst ? 0 : $urandom_range(0, 14);
    if (hold_req && !hold_done) begin
      hold_left = 400;
      hold_done = 1;
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic push_item(tli_pkg::op_e op, int row, int col, logic [31:0] t,
                           logic [31:0] s);
    table_item_t it;
    it.op   = op;
    it.row  = row[5:0];
    it.col  = col[2:0];
    it.tval = t;
    it.sval = s;
    pending_q.push_back(it);
    if (op == tli_pkg::OP_TIME) begin
      gen_time[row]   = t;
      time_known[row] = 1;
    end else if (op == tli_pkg::OP_SAMPLE) begin
      sample_known[row][col] = 1;
    end
  endtask

  task automatic write_reg(tli_pkg::reg_e idx, logic [7:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == tli_pkg::REG_POINTS) points_cfg = value[6:0];
    else if (idx == tli_pkg::REG_COLUMNS) columns_cfg = value[3:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drain: everything sent, every result back, then let a trailing load settle.
  task automatic wait_drained();
    while (pending_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Ascending time points with occasional repeats, samples for unwritten cells.
  task automatic fill_table(int n, int cols);
    longint start, t;
    phase_step = longint'($urandom_range(1, 32'h00FF_FFFF));
    start = -(longint'(n) * phase_step) / 2 + longint'($urandom_range(0, 1000));
    for (int r = 0; r < n; r++) begin
      t = start + longint'(r) * phase_step;
      if (r > 0 && $urandom_range(0, 7) == 0) t = longint'($signed(gen_time[r-1]));
      push_item(tli_pkg::OP_TIME, r, $urandom_range(0, 7), t[31:0], $urandom);
    end
    for (int r = 0; r < n; r++)
      for (int c = 0; c < cols; c++)
        if (!sample_known[r][c]) push_item(tli_pkg::OP_SAMPLE, r, c, $urandom, $urandom);
  endtask

  task automatic random_item(int n);
    int     k, row;
    longint x;
    k = $urandom_range(0, 99);
    if (k < 70) begin
      case ($urandom_range(0, 9))
        0: x = longint'($signed($urandom));
        1: x = longint'($signed(gen_time[0])) - longint'($urandom_range(0, 1000));
        2: x = longint'($signed(gen_time[n-1])) + longint'($urandom_range(0, 1000));
        default: begin
          row = $urandom_range(0, n - 1);
          x = longint'($signed(gen_time[row]))
              - longint'($urandom_range(0, 32'(phase_step)));
        end
      endcase
      if (x < -64'sd2147483648) x = -64'sd2147483648;
      if (x > 64'sd2147483647) x = 64'sd2147483647;
      push_item(tli_pkg::OP_QUERY, $urandom_range(0, 63), $urandom_range(0, 7), x[31:0],
                $urandom);
    end else if (k < 85) begin
      push_item(tli_pkg::OP_SAMPLE, $urandom_range(0, 63), $urandom_range(0, 7), $urandom,
                $urandom);
    end else if (k < 90 && n < 64) begin
      // Rows past the ones in use keep the active table sorted.
      push_item(tli_pkg::OP_TIME, $urandom_range(n, 63), $urandom_range(0, 7), $urandom,
                $urandom);
    end else if (k < 94) begin
      // Occasional unsorted point inside the active range.
      push_item(tli_pkg::OP_TIME, $urandom_range(0, n - 1), $urandom_range(0, 7), $urandom,
                $urandom);
    end else begin
      push_item(tli_pkg::OP_NONE, $urandom_range(0, 63), $urandom_range(0, 7), $urandom,
                $urandom);
    end
  endtask

  initial begin
    int n, cols;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, reset settings (one point, eight columns): extreme samples and times.
    gap_burst   = 0;
    stall_burst = 0;
    push_item(tli_pkg::OP_TIME, 0, 0, 32'h0000_0000, 32'h0);
    push_item(tli_pkg::OP_SAMPLE, 0, 0, 32'h0, 32'h8000_0000);
    push_item(tli_pkg::OP_SAMPLE, 0, 1, 32'h0, 32'h7FFF_FFFF);
    push_item(tli_pkg::OP_SAMPLE, 0, 2, 32'h0, 32'h0000_0000);
    push_item(tli_pkg::OP_SAMPLE, 0, 3, 32'h0, 32'hFFFF_FFFF);
    for (int c = 4; c < 8; c++) push_item(tli_pkg::OP_SAMPLE, 0, c, 32'h0, $urandom);
    push_item(tli_pkg::OP_QUERY, 0, 0, 32'h8000_0000, 32'h0);  // below the first point
    push_item(tli_pkg::OP_QUERY, 63, 7, 32'h7FFF_FFFF, 32'hFFFF_FFFF);  // past the end
    push_item(tli_pkg::OP_QUERY, 0, 0, 32'h0, 32'h0);  // exactly on the point
    push_item(tli_pkg::OP_NONE, 63, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // unused op code
    push_item(tli_pkg::OP_TIME, 63, 7, 32'h7FFF_FFFF, 32'h8000_0000);
    push_item(tli_pkg::OP_SAMPLE, 63, 7, 32'h8000_0000, 32'h8000_0000);
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      write_reg(tli_pkg::REG_POINTS, points_w[p]);
      write_reg(tli_pkg::REG_COLUMNS, columns_w[p]);
      if (p == 1) begin
        write_reg(tli_pkg::REG_RSVD2, 8'hFF);
        write_reg(tli_pkg::REG_RSVD3, 8'h00);
      end
      n    = (points_cfg == 0) ? 1 : ((points_cfg > 64) ? 64 : points_cfg);
      cols = (columns_cfg == 0) ? 1 : ((columns_cfg > 8) ? 8 : columns_cfg);
      gap_burst   = ($urandom_range(0, 3) == 0);
      stall_burst = ($urandom_range(0, 3) == 0);
      if (p == 0) begin
        // Interpolation between extreme points and extreme samples.
        phase_step = 32'h0001_0000;
        push_item(tli_pkg::OP_TIME, 0, 0, 32'h8000_0000, 32'h0);
        push_item(tli_pkg::OP_TIME, 1, 0, 32'h0000_0000, 32'h0);
        push_item(tli_pkg::OP_TIME, 2, 0, 32'h0001_0000, 32'h0);
        push_item(tli_pkg::OP_TIME, 3, 0, 32'h7FFF_FFFF, 32'h0);
        for (int r = 0; r < 4; r++) begin
          push_item(tli_pkg::OP_SAMPLE, r, 0, 32'h0, r[0] ? 32'h7FFF_FFFF : 32'h8000_0000);
          push_item(tli_pkg::OP_SAMPLE, r, 1, 32'h0, $urandom);
        end
        push_item(tli_pkg::OP_QUERY, 0, 0, 32'h0000_0001, 32'h0);
        push_item(tli_pkg::OP_QUERY, 0, 0, 32'h0000_8000, 32'h0);
        push_item(tli_pkg::OP_QUERY, 0, 0, 32'h4000_0000, 32'h0);
        push_item(tli_pkg::OP_QUERY, 0, 0, 32'hC000_0000, 32'h0);
      end else begin
        fill_table(n, cols);
      end
      // Hold the receiver off in the first eight-column phase while queries keep coming.
      if (cols == 8) hold_req = 1;
      for (int i = 0; i < ItemsPerPhase; i++) random_item(n);
      wait_drained();
    end

    $display("Checked %0d column results from %0d queries over %0d table settings.",
             result_count, query_count, NumPhases + 1);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
